// ===== src/ssvc_pkg.sv =====
// Shared types, constants and the arctangent table for the visibility counter.
package ssvc_pkg;

    localparam int unsigned DEF_NUM_BINS     = 1024;
    localparam int unsigned DEF_INDEX_WIDTH  = 16;
    localparam int unsigned DEF_CORDIC_STEPS = 16;

    localparam int unsigned PW = 27;   // pose-transformed coordinate
    localparam int unsigned XW = 38;   // CORDIC x/y
    localparam int unsigned ZW = 34;   // CORDIC angle, 2^-30 rad
    localparam int unsigned RW = 20;   // range

    localparam logic [RW-1:0]        EMPTY_RANGE  = 20'd1024000;
    localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;
    localparam logic [15:0]          INV_GAIN_Q16 = 16'd39797;
    localparam logic [RW-1:0]        NEAR2_LIMIT  = 20'd1024;
    localparam logic [RW-1:0]        NEAR1_LIMIT  = 20'd1792;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_COS    = 3'd0,
        CFG_SIN    = 3'd1,
        CFG_TX     = 3'd2,
        CFG_TY     = 3'd3,
        CFG_FLOOR  = 3'd4,
        CFG_CEIL   = 3'd5,
        CFG_BPR    = 3'd6,
        CFG_UNUSED = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_XF1, S_XF2, S_CORD, S_MUL1, S_MUL2, S_SUM, S_CHK, S_BINS
    } t_state;

    typedef enum logic [2:0] {
        BS_CLEAR, BS_IDLE, BS_RMW, BS_RDWAIT, BS_FIN
    } t_bin_state;

    typedef enum logic [1:0] {
        BOP_INSERT, BOP_READ, BOP_CLEAR
    } t_bin_op;

    typedef struct packed {
        logic    valid;
        t_bin_op op;
        logic    intr;
    } t_bin_cmd;

    typedef struct packed {
        logic done;
        logic owner_valid;
        logic owner_intr;
    } t_bin_rsp;

    function automatic logic signed [ZW-1:0] ssvc_atan(input logic [4:0] i);
        logic signed [ZW-1:0] a;
        unique case (i)
            5'd0:  a = 34'sh03243F6A8;
            5'd1:  a = 34'sh01DAC6705;
            5'd2:  a = 34'sh00FADBAFC;
            5'd3:  a = 34'sh007F56EA6;
            5'd4:  a = 34'sh003FEAB76;
            5'd5:  a = 34'sh001FFD55B;
            5'd6:  a = 34'sh000FFFAAA;
            5'd7:  a = 34'sh0007FFF55;
            5'd8:  a = 34'sh0003FFFEA;
            5'd9:  a = 34'sh0001FFFFD;
            5'd10: a = 34'sh0000FFFFF;
            5'd11: a = 34'sh00007FFFF;
            5'd12: a = 34'sh00003FFFF;
            5'd13: a = 34'sh00001FFFF;
            5'd14: a = 34'sh00000FFFF;
            5'd15: a = 34'sh000007FFF;
            5'd16: a = 34'sh000003FFF;
            5'd17: a = 34'sh000001FFF;
            5'd18: a = 34'sh000000FFF;
            5'd19: a = 34'sh0000007FF;
            5'd20: a = 34'sh0000003FF;
            5'd21: a = 34'sh0000001FF;
            5'd22: a = 34'sh0000000FF;
            5'd23: a = 34'sh00000007F;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== src/ssvc_cordic.sv =====
// Iterative vectoring CORDIC: one micro-rotation per cycle, gives magnitude and angle.
module ssvc_cordic #(
    parameter int unsigned CORDIC_STEPS = ssvc_pkg::DEF_CORDIC_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [ssvc_pkg::PW-1:0]    i_px,
    input  logic signed [ssvc_pkg::PW-1:0]    i_py,
    output logic                              o_done,
    output logic signed [ssvc_pkg::XW-1:0]    o_x,
    output logic signed [ssvc_pkg::ZW-1:0]    o_z
);
    import ssvc_pkg::*;

    localparam int unsigned IW = $clog2(CORDIC_STEPS);
    localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

    logic [IW-1:0]        r_i;
    logic                 r_busy;
    logic                 r_done;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [XW-1:0] cx0, cy0, sx, sy;
    logic signed [ZW-1:0] at;

    always_comb begin
        cx0 = XW'(i_px) <<< 8;
        cy0 = XW'(i_py) <<< 8;
        sx  = r_x >>> r_i;
        sy  = r_y >>> r_i;
        at  = ssvc_atan(5'(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            if (i_px < 0) begin
                r_x <= -cx0;
                r_y <= -cy0;
                r_z <= (i_py >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
                r_x <= cx0;
                r_y <= cy0;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - at;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_z    = r_z;

endmodule

// ===== src/ssvc_bins.sv =====
// Bin store: range/owner memory with clearing pass, read and read-modify-write insert.
module ssvc_bins #(
    parameter int unsigned NUM_BINS    = ssvc_pkg::DEF_NUM_BINS,
    parameter int unsigned INDEX_WIDTH = ssvc_pkg::DEF_INDEX_WIDTH,
    localparam int unsigned AW = $clog2(NUM_BINS),
    localparam int unsigned CW = $clog2(NUM_BINS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ssvc_pkg::t_bin_cmd          i_cmd,
    input  logic [9:0]                  i_sel,
    input  logic [AW-1:0]               i_lo,
    input  logic [AW-1:0]               i_hi,
    input  logic [AW-1:0]               i_ctr,
    input  logic [ssvc_pkg::RW-1:0]     i_dist,
    input  logic [INDEX_WIDTH-1:0]      i_idx,
    output logic                        o_ready,
    output ssvc_pkg::t_bin_rsp          o_rsp,
    output logic [ssvc_pkg::RW-1:0]     o_range,
    output logic [INDEX_WIDTH-1:0]      o_owner,
    output logic [CW-1:0]               o_count
);
    import ssvc_pkg::*;

    localparam int unsigned WW   = RW + 2 + INDEX_WIDTH;
    localparam int unsigned SELW = ((AW > 10) ? AW : 10) + 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_BINS - 1);
    localparam logic [WW-1:0] EMPTY_WORD = {EMPTY_RANGE, 2'b00, {INDEX_WIDTH{1'b0}}};

    logic [WW-1:0] mem [NUM_BINS];
    logic [WW-1:0] r_rdata;

    t_bin_state r_state, n_state;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_hi, r_ctr;
    logic [RW-1:0]          r_dist;
    logic [INDEX_WIDTH-1:0] r_idx;
    logic                   r_intr, r_oob;

    logic                   we;
    logic [AW-1:0]          wa, ra;
    logic [WW-1:0]          wd;
    logic [SELW-1:0]        sel_ext;
    logic                   sel_oob;
    logic [RW-1:0]          old_range;
    logic [1:0]             old_flags, new_flags;
    logic [INDEX_WIDTH-1:0] old_owner;

    always_comb begin
        sel_ext   = SELW'(i_sel);
        sel_oob   = sel_ext >= SELW'(NUM_BINS);
        old_range = r_rdata[WW-1 -: RW];
        old_flags = r_rdata[INDEX_WIDTH +: 2];
        old_owner = r_rdata[INDEX_WIDTH-1:0];
    end

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_count   = r_count;
        we        = 1'b0;
        wa        = r_ptr;
        wd        = EMPTY_WORD;
        ra        = r_ptr;
        new_flags = 2'b00;
        unique case (r_state)
            BS_CLEAR: begin
                we      = 1'b1;
                n_count = '0;
                if (r_ptr == LAST) begin
                    n_state = BS_FIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            BS_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.op)
                        BOP_CLEAR: begin
                            n_ptr   = '0;
                            n_state = BS_CLEAR;
                        end
                        BOP_READ: begin
                            ra      = sel_ext[AW-1:0];
                            n_state = BS_RDWAIT;
                        end
                        BOP_INSERT: begin
                            ra      = i_lo;
                            n_ptr   = i_lo;
                            n_state = BS_RMW;
                        end
                        default: n_state = BS_IDLE;
                    endcase
                end
            end
            BS_RMW: begin
                new_flags = (r_ptr == r_ctr) ? {r_intr, 1'b1} : 2'b00;
                if (r_dist < old_range) begin
                    we      = 1'b1;
                    wd      = {r_dist, new_flags, (r_ptr == r_ctr) ? r_idx : old_owner};
                    n_count = r_count - CW'(old_flags == 2'b11) + CW'(new_flags == 2'b11);
                end
                if (r_ptr == r_hi) begin
                    n_state = BS_FIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                    ra    = r_ptr + 1'b1;
                end
            end
            BS_RDWAIT: n_state = BS_IDLE;
            BS_FIN:    n_state = BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
            r_ptr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BS_IDLE && i_cmd.valid) begin
            r_hi   <= i_hi;
            r_ctr  <= i_ctr;
            r_dist <= i_dist;
            r_idx  <= i_idx;
            r_intr <= i_cmd.intr;
            r_oob  <= sel_oob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rdata <= mem[ra];
    end

    always_comb begin
        o_ready           = r_state == BS_IDLE;
        o_rsp.done        = r_state == BS_FIN || r_state == BS_RDWAIT;
        o_rsp.owner_valid = !r_oob && old_flags[0];
        o_rsp.owner_intr  = !r_oob && old_flags[0] && old_flags[1];
        o_range           = r_oob ? EMPTY_RANGE : old_range;
        o_owner           = o_rsp.owner_valid ? old_owner : '0;
        o_count           = r_count;
    end

endmodule

// ===== src/sparse_scan_visibility_counter_top.sv =====
// Top level: configuration, pose transform, range/bin arithmetic and sequencing.
// Insert: transform (XF1, XF2), CORDIC, then MUL1, MUL2, SUM and CHK; a point
//   in window and span gets one read-modify-write store beat per bin it claims.
// Read: one store read. Clear: a pass over every bin. Unused mode: no busy, no store.
// One item at a time; otherwise busy is high from acceptance until the result strobe.
// Reset clears the store by a pass over every bin, busy throughout; no stall.
module sparse_scan_visibility_counter_top #(
    parameter int unsigned NUM_BINS     = ssvc_pkg::DEF_NUM_BINS,
    parameter int unsigned INDEX_WIDTH  = ssvc_pkg::DEF_INDEX_WIDTH,
    parameter int unsigned CORDIC_STEPS = ssvc_pkg::DEF_CORDIC_STEPS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [23:0]            i_cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_mode,
    input  logic signed [23:0]     i_point_x,
    input  logic signed [23:0]     i_point_y,
    input  logic [INDEX_WIDTH-1:0] i_point_number,
    input  logic                   i_is_interesting,
    input  logic [9:0]             i_bin_select,
    output logic                   o_valid,
    output logic [10:0]            o_visible_count,
    output logic                   o_point_accepted,
    output logic [9:0]             o_centre_bin,
    output logic [19:0]            o_read_range,
    output logic [INDEX_WIDTH-1:0] o_read_owner,
    output logic                   o_read_owner_valid,
    output logic                   o_read_owner_interesting
);
    import ssvc_pkg::*;

    localparam int unsigned AW = $clog2(NUM_BINS);
    localparam int unsigned CW = $clog2(NUM_BINS + 1);
    localparam logic signed [61:0] BIAS = (62'(NUM_BINS) << 37) + (62'sd1 <<< 37);

    logic signed [15:0] r_cos, r_sin;
    logic signed [23:0] r_tx, r_ty;
    logic [19:0]        r_floor, r_ceil;
    logic [23:0]        r_bpr;

    t_state r_state, n_state;
    t_mode  r_mode;
    logic signed [23:0]     r_x, r_y;
    logic [INDEX_WIDTH-1:0] r_idx;
    logic                   r_intr;
    logic signed [39:0]     r_p0, r_p1, r_p2, r_p3;
    logic [34:0]            r_dlo;
    logic [33:0]            r_dhi;
    logic signed [46:0]     r_zlo, r_zhi;
    logic [29:0]            r_dist;
    logic signed [23:0]     r_bin;

    logic signed [40:0]     sum_x, sum_y;
    logic signed [PW-1:0]   px, py;
    logic [53:0]            dsum;
    logic signed [61:0]     tsum;
    logic                   accept, cord_start, cord_done, out_load;
    logic signed [XW-1:0]   cord_x;
    logic signed [ZW-1:0]   cord_z;
    logic                   in_window, in_span;
    logic signed [AW+1:0]   b_s, lo_s, hi_s;
    logic [1:0]             wid;
    logic [AW-1:0]          lo, hi;

    t_bin_cmd               bcmd;
    t_bin_rsp               brsp;
    logic                   bready;
    logic [RW-1:0]          b_range;
    logic [INDEX_WIDTH-1:0] b_owner;
    logic [CW-1:0]          b_count;

    logic                   n_acc, n_rov, n_roi;
    logic [9:0]             n_centre;
    logic [19:0]            n_range;
    logic [INDEX_WIDTH-1:0] n_owner;

    assign busy   = (r_state != S_IDLE) || !bready;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos   <= 16'sd32767;
            r_sin   <= '0;
            r_tx    <= '0;
            r_ty    <= '0;
            r_floor <= 20'd102;
            r_ceil  <= 20'd30720;
            r_bpr   <= 24'd55631;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COS:    r_cos   <= i_cfg_data[15:0];
                CFG_SIN:    r_sin   <= i_cfg_data[15:0];
                CFG_TX:     r_tx    <= i_cfg_data;
                CFG_TY:     r_ty    <= i_cfg_data;
                CFG_FLOOR:  r_floor <= i_cfg_data[19:0];
                CFG_CEIL:   r_ceil  <= i_cfg_data[19:0];
                CFG_BPR:    r_bpr   <= i_cfg_data;
                CFG_UNUSED: r_bpr   <= r_bpr;
                default:    r_bpr   <= r_bpr;
            endcase
        end
    end

    always_comb begin
        sum_x = 41'(r_p0) - 41'(r_p1) + 41'sd16384;
        sum_y = 41'(r_p2) + 41'(r_p3) + 41'sd16384;
        px    = PW'(sum_x >>> 15) + PW'(r_tx);
        py    = PW'(sum_y >>> 15) + PW'(r_ty);
        dsum  = (54'(r_dhi) << 19) + 54'(r_dlo) + 54'(24'h800000);
        tsum  = (62'(r_zhi) <<< 12) + 62'(r_zlo) + BIAS;

        in_window = (r_dist >= 30'(r_floor)) && (r_dist <= 30'(r_ceil));
        in_span   = (r_bin >= 0) && (r_bin < $signed(24'(NUM_BINS)));
        b_s       = $signed({2'b00, r_bin[AW-1:0]});
        if (r_dist <= 30'(NEAR2_LIMIT)) begin
            wid = 2'd2;
        end else if (r_dist <= 30'(NEAR1_LIMIT)) begin
            wid = 2'd1;
        end else begin
            wid = 2'd0;
        end
        lo_s = b_s - $signed((AW+2)'(wid));
        hi_s = b_s + $signed((AW+2)'(wid));
        lo   = (lo_s < 0) ? '0 : lo_s[AW-1:0];
        hi   = (hi_s > $signed((AW+2)'(NUM_BINS - 1))) ? AW'(NUM_BINS - 1) : hi_s[AW-1:0];
    end

    always_comb begin
        n_state    = r_state;
        cord_start = 1'b0;
        out_load   = 1'b0;
        bcmd.valid = 1'b0;
        bcmd.op    = BOP_INSERT;
        bcmd.intr  = r_intr;
        n_acc      = 1'b0;
        n_centre   = '0;
        n_range    = '0;
        n_owner    = '0;
        n_rov      = 1'b0;
        n_roi      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_mode'(i_mode))
                        MODE_INSERT: n_state = S_XF1;
                        MODE_READ: begin
                            bcmd.valid = 1'b1;
                            bcmd.op    = BOP_READ;
                            n_state    = S_BINS;
                        end
                        MODE_CLEAR: begin
                            bcmd.valid = 1'b1;
                            bcmd.op    = BOP_CLEAR;
                            n_state    = S_BINS;
                        end
                        MODE_NONE: out_load = 1'b1;
                        default:   out_load = 1'b1;
                    endcase
                end
            end
            S_XF1: n_state = S_XF2;
            S_XF2: begin
                cord_start = 1'b1;
                n_state    = S_CORD;
            end
            S_CORD: begin
                if (cord_done) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = S_CHK;
            S_CHK: begin
                if (in_window && in_span) begin
                    bcmd.valid = 1'b1;
                    bcmd.op    = BOP_INSERT;
                    n_state    = S_BINS;
                end else begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_BINS: begin
                if (brsp.done) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (r_mode == MODE_INSERT) begin
                        n_acc    = 1'b1;
                        n_centre = 10'(r_bin);
                    end else if (r_mode == MODE_READ) begin
                        n_range = b_range;
                        n_owner = b_owner;
                        n_rov   = brsp.owner_valid;
                        n_roi   = brsp.owner_intr;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_mode);
            r_x    <= i_point_x;
            r_y    <= i_point_y;
            r_idx  <= i_point_number;
            r_intr <= i_is_interesting;
        end
        if (r_state == S_XF1) begin
            r_p0 <= r_cos * r_x;
            r_p1 <= r_sin * r_y;
            r_p2 <= r_sin * r_x;
            r_p3 <= r_cos * r_y;
        end
        if (r_state == S_MUL1) begin
            r_dlo <= {16'b0, cord_x[18:0]} * 35'(INV_GAIN_Q16);
            r_dhi <= {16'b0, cord_x[36:19]} * 34'(INV_GAIN_Q16);
        end
        if (r_state == S_MUL2) begin
            r_zlo <= cord_z * $signed({1'b0, r_bpr[11:0]});
            r_zhi <= cord_z * $signed({1'b0, r_bpr[23:12]});
        end
        if (r_state == S_SUM) begin
            r_dist <= 30'(dsum >> 24);
            r_bin  <= 24'(tsum >>> 38);
        end
        if (out_load) begin
            o_visible_count          <= (32'(b_count) > 32'd2047) ? 11'd2047 : 11'(b_count);
            o_point_accepted         <= n_acc;
            o_centre_bin             <= n_centre;
            o_read_range             <= n_range;
            o_read_owner             <= n_owner;
            o_read_owner_valid       <= n_rov;
            o_read_owner_interesting <= n_roi;
        end
    end

    ssvc_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_px    (px),
        .i_py    (py),
        .o_done  (cord_done),
        .o_x     (cord_x),
        .o_z     (cord_z)
    );

    ssvc_bins #(
        .NUM_BINS    (NUM_BINS),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_bins (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (bcmd),
        .i_sel   (i_bin_select),
        .i_lo    (lo),
        .i_hi    (hi),
        .i_ctr   (r_bin[AW-1:0]),
        .i_dist  (r_dist[RW-1:0]),
        .i_idx   (r_idx),
        .o_ready (bready),
        .o_rsp   (brsp),
        .o_range (b_range),
        .o_owner (b_owner),
        .o_count (b_count)
    );

    a_cmd_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bcmd.valid |-> bready)
        else $error("store command while store busy");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_point_accepted && o_read_owner_valid))
        else $error("insert and read result mixed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(b_count) <= NUM_BINS)
        else $error("visible count above bin count");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> r_state == S_CORD)
        else $error("CORDIC finished outside its wait state");

endmodule

// ===== test/ssvc_scan_checker.sv =====
// Checker for the visibility counter: mirrors the scan store, predicts and compares result beats.
module ssvc_scan_checker
    import ssvc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [1:0]         i_mode,
    input  logic signed [23:0] i_point_x,
    input  logic signed [23:0] i_point_y,
    input  logic [15:0]        i_point_number,
    input  logic               i_is_interesting,
    input  logic [9:0]         i_bin_select,
    input  logic               i_valid,
    input  logic [10:0]        i_visible_count,
    input  logic               i_point_accepted,
    input  logic [9:0]         i_centre_bin,
    input  logic [19:0]        i_read_range,
    input  logic [15:0]        i_read_owner,
    input  logic               i_read_owner_valid,
    input  logic               i_read_owner_interesting,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int BINS = 1024;

    typedef struct packed {
        logic [10:0] visible;
        logic        accepted;
        logic [9:0]  centre;
        logic [19:0] range;
        logic [15:0] owner;
        logic        owner_valid;
        logic        owner_intr;
    } t_scan_result;

    localparam longint ARCTAN [16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    logic signed [15:0] rot_cos, rot_sin;
    logic signed [23:0] shift_x, shift_y;
    logic [19:0]        win_lo, win_hi;
    logic [23:0]        bin_scale;
    logic [19:0]        zbuf [BINS];
    logic [15:0]        zbuf_owner [BINS];
    logic [1:0]         zbuf_flags [BINS];
    int                 owned_total;
    t_scan_result       scan_expected [$];
    int                 fails, checked;

    function automatic void wipe_scan();
        for (int k = 0; k < BINS; k++) begin
            zbuf[k] = EMPTY_RANGE;
            zbuf_owner[k] = '0;
            zbuf_flags[k] = '0;
        end
        owned_total = 0;
    endfunction

    function automatic void project_point(input logic signed [23:0] x,
                                          input logic signed [23:0] y,
                                          input logic [15:0] num, input logic intr,
                                          inout t_scan_result r);
        longint px, py, cx, cy, z, nx, ny, rng, t, bin, lo, hi;
        logic [1:0] nf;
        px = ((longint'(rot_cos) * x - longint'(rot_sin) * y + (64'sd1 <<< 14)) >>> 15)
             + longint'(shift_x);
        py = ((longint'(rot_sin) * x + longint'(rot_cos) * y + (64'sd1 <<< 14)) >>> 15)
             + longint'(shift_y);
        cx = px * 256;
        cy = py * 256;
        z = 0;
        if (cx < 0) begin
            z = (cy >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < 16; i++) begin
            if (cy >= 0) begin
                nx = cx + (cy >>> i);
                ny = cy - (cx >>> i);
                z += ARCTAN[i];
            end else begin
                nx = cx - (cy >>> i);
                ny = cy + (cx >>> i);
                z -= ARCTAN[i];
            end
            cx = nx;
            cy = ny;
        end
        rng = (cx * 39797 + (64'sd1 <<< 23)) >>> 24;
        if (rng < longint'(win_lo) || rng > longint'(win_hi)) return;
        t = z * longint'(bin_scale) + (64'sd1024 <<< 37) + (64'sd1 <<< 37);
        bin = t >>> 38;
        if (bin < 0 || bin >= BINS) return;
        r.accepted = 1'b1;
        r.centre = bin[9:0];
        lo = bin;
        hi = bin;
        if (rng <= 1024) begin
            lo = bin - 2;
            hi = bin + 2;
        end else if (rng <= 1792) begin
            lo = bin - 1;
            hi = bin + 1;
        end
        if (lo < 0) lo = 0;
        if (hi > BINS - 1) hi = BINS - 1;
        for (longint k = lo; k <= hi; k++) begin
            if (rng >= longint'(zbuf[k])) continue;
            zbuf[k] = rng[19:0];
            if (zbuf_flags[k] == 2'b11) owned_total--;
            if (k == bin) begin
                zbuf_owner[k] = num;
                nf = {intr, 1'b1};
            end else begin
                nf = 2'b00;
            end
            zbuf_flags[k] = nf;
            if (nf == 2'b11) owned_total++;
        end
    endfunction

    function automatic t_scan_result predict_scan(input t_mode m,
                                                  input logic signed [23:0] x,
                                                  input logic signed [23:0] y,
                                                  input logic [15:0] num, input logic intr,
                                                  input logic [9:0] sel);
        t_scan_result r;
        r = '0;
        case (m)
            MODE_INSERT: project_point(x, y, num, intr, r);
            MODE_READ: begin
                r.range = zbuf[sel];
                if (zbuf_flags[sel][0]) begin
                    r.owner = zbuf_owner[sel];
                    r.owner_valid = 1'b1;
                    r.owner_intr = zbuf_flags[sel][1];
                end
            end
            MODE_CLEAR: wipe_scan();
            default: ;
        endcase
        r.visible = (owned_total > 2047) ? 11'd2047 : owned_total[10:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_scan_result got, want;
        if (!i_rst_n) begin
            rot_cos = 16'sd32767;
            rot_sin = '0;
            shift_x = '0;
            shift_y = '0;
            win_lo = 20'd102;
            win_hi = 20'd30720;
            bin_scale = 24'd55631;
            wipe_scan();
            scan_expected.delete();
            fails = 0;
            checked = 0;
        end else begin
            if (i_valid) begin
                got = '{i_visible_count, i_point_accepted, i_centre_bin, i_read_range,
                        i_read_owner, i_read_owner_valid, i_read_owner_interesting};
                if (scan_expected.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = scan_expected.pop_front();
                    checked++;
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10) $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
            if (i_start && !i_busy)
                scan_expected.push_back(predict_scan(t_mode'(i_mode), i_point_x, i_point_y,
                                        i_point_number, i_is_interesting, i_bin_select));
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_COS:   rot_cos = i_cfg_data[15:0];
                    CFG_SIN:   rot_sin = i_cfg_data[15:0];
                    CFG_TX:    shift_x = i_cfg_data;
                    CFG_TY:    shift_y = i_cfg_data;
                    CFG_FLOOR: win_lo = i_cfg_data[19:0];
                    CFG_CEIL:  win_hi = i_cfg_data[19:0];
                    CFG_BPR:   bin_scale = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails + scan_expected.size() * 0;
        o_pending <= scan_expected.size();
        o_checked <= checked;
    end

endmodule

// ===== test/sparse_scan_visibility_counter_top_test.sv =====
// Testbench top: drives configuration phases and scan items, reports the verdict.
module sparse_scan_visibility_counter_top_test;
    import ssvc_pkg::*;

    logic               i_clk, i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [23:0]        i_cfg_data;
    logic               start, busy;
    logic [1:0]         i_mode;
    logic signed [23:0] i_point_x, i_point_y;
    logic [15:0]        i_point_number;
    logic               i_is_interesting;
    logic [9:0]         i_bin_select;
    logic               o_valid, o_point_accepted, o_read_owner_valid;
    logic               o_read_owner_interesting;
    logic [10:0]        o_visible_count;
    logic [9:0]         o_centre_bin;
    logic [19:0]        o_read_range;
    logic [15:0]        o_read_owner;
    int                 fail_count, pending, checked;
    int                 idle_pct, items_sent, near_span;

    sparse_scan_visibility_counter_top dut (.*);

    ssvc_scan_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_start(start), .i_busy(busy), .i_mode, .i_point_x, .i_point_y,
        .i_point_number, .i_is_interesting, .i_bin_select,
        .i_valid(o_valid), .i_visible_count(o_visible_count),
        .i_point_accepted(o_point_accepted), .i_centre_bin(o_centre_bin),
        .i_read_range(o_read_range), .i_read_owner(o_read_owner),
        .i_read_owner_valid(o_read_owner_valid),
        .i_read_owner_interesting(o_read_owner_interesting),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 3000000);
        $display("FAIL");
        $finish;
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_pose(input int c, input int s, input int tx, input int ty,
                            input int lo, input int hi, input int bpr);
        cfg_write(CFG_COS, 24'(c));
        cfg_write(CFG_SIN, 24'(s));
        cfg_write(CFG_TX, 24'(tx));
        cfg_write(CFG_TY, 24'(ty));
        cfg_write(CFG_FLOOR, 24'(lo));
        cfg_write(CFG_CEIL, 24'(hi));
        cfg_write(CFG_BPR, 24'(bpr));
        cfg_write(CFG_UNUSED, 24'hA5A5A5);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_beat(input t_mode m, input int x, input int y,
                             input int num, input bit intr, input int sel);
        start <= 1'b1;
        i_mode <= m;
        i_point_x <= 24'(x);
        i_point_y <= 24'(y);
        i_point_number <= 16'(num);
        i_is_interesting <= intr;
        i_bin_select <= 10'(sel);
        do @(posedge i_clk); while (busy);
        items_sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int spread(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic random_beats(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                send_beat(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 3)
                send_beat(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 25)
                send_beat(MODE_READ, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 33)
                send_beat(MODE_INSERT, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (r < 65)
                send_beat(MODE_INSERT, spread(near_span), spread(near_span), $urandom,
                          $urandom, $urandom);
            else
                send_beat(MODE_INSERT, spread(32000), spread(32000), $urandom,
                          $urandom, $urandom);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        start = 1'b0;
        i_mode = MODE_NONE;
        i_point_x = '0;
        i_point_y = '0;
        i_point_number = '0;
        i_is_interesting = 1'b0;
        i_bin_select = '0;
        items_sent = 0;
        idle_pct = 0;
        near_span = 1900;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy);

        // defaults, directed edges first
        set_pose(32767, 0, 0, 0, 102, 30720, 55631);
        send_beat(MODE_READ, 0, 0, 0, 0, 0);
        send_beat(MODE_INSERT, 2000, 0, 65535, 1, 0);
        send_beat(MODE_INSERT, 2000, 0, 1234, 0, 0);
        send_beat(MODE_INSERT, 500, 0, 7, 1, 0);
        send_beat(MODE_INSERT, 1500, 10, 9, 1, 0);
        send_beat(MODE_INSERT, -500, 1, 0, 1, 0);
        send_beat(MODE_INSERT, -500, -1, 3, 1, 0);
        send_beat(MODE_INSERT, -1500, 0, 4, 0, 0);
        send_beat(MODE_INSERT, 8388607, 8388607, 5, 1, 0);
        send_beat(MODE_INSERT, -8388608, -8388608, 6, 1, 0);
        send_beat(MODE_INSERT, 50, 0, 8, 1, 0);
        send_beat(MODE_INSERT, 30720, 0, 10, 1, 0);
        send_beat(MODE_INSERT, 0, 30000, 11, 1, 0);
        send_beat(MODE_READ, 0, 0, 0, 0, 512);
        send_beat(MODE_READ, 0, 0, 0, 0, 0);
        send_beat(MODE_READ, 0, 0, 0, 0, 1023);
        send_beat(MODE_READ, 0, 0, 0, 0, 511);
        send_beat(MODE_NONE, -1, -1, 65535, 1, 1023);
        send_beat(MODE_CLEAR, 0, 0, 0, 0, 0);
        send_beat(MODE_READ, 0, 0, 0, 0, 512);
        random_beats(400);
        drain();

        idle_pct = 68;
        set_pose(0, 32767, 500, -300, 0, 1048575, 55631);
        random_beats(400);
        drain();

        idle_pct = 35;
        set_pose(-32768, -32768, 8388607, -8388608, 1048575, 0, 16777215);
        random_beats(60);
        drain();

        idle_pct = 0;
        set_pose(23170, 23170, spread(800), spread(800), 102, 30720, 1);
        random_beats(150);
        drain();

        idle_pct = 68;
        set_pose(spread(32767), spread(32767), spread(1500), spread(1500),
                 $urandom_range(0, 300), $urandom_range(20000, 40000), 40000);
        random_beats(350);
        drain();

        idle_pct = 35;
        set_pose(32767, 0, 0, 0, 102, 30720, 55631);
        random_beats(350);
        drain();

        $display("Drove %0d scan beats over six pose/window settings, %0d results checked.",
                 items_sent, checked);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
